// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tile background video unit checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define TBV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tbv assertion failed");

// Clocked assertion that is also checked during reset.
`define TBV_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tbv reset assertion failed");

`endif

// ----- rtl/core/tbv_pkg.sv -----
// ----------------------------------------------------------------------------
// tbv_pkg
// Types, codes and constants shared by the tile background video unit.
// ----------------------------------------------------------------------------
package tbv_pkg;

    localparam int CNT_W       = 9;
    localparam int PAT_AW      = 12;
    localparam int BANK_AW     = 11;
    localparam int TILE_AW     = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0] VIS_FIRST   = 9'd1;
    localparam logic [CNT_W-1:0] VIS_LAST_Y  = 9'd240;
    localparam logic [CNT_W-1:0] VIS_LAST_X  = 9'd256;

    localparam logic [15:0] PATTERN_LIMIT = 16'h1000;
    localparam logic [15:0] TILE_BASE     = 16'h2000;
    localparam logic [15:0] TILE_LIMIT    = 16'h2400;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic EV_PIXEL  = 1'b0;
    localparam logic EV_VBLANK = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_REG_WRITE = 2'd1,
        CMD_PAT_LOAD  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_PIXEL      = 2'd0,
        OP_VBLANK     = 2'd1,
        OP_PAT_WRITE  = 2'd2,
        OP_TILE_WRITE = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [PAT_AW-1:0] addr;
        logic [7:0]        data;
        logic              nmi;
        logic              vflag;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [1:0] color_index;
        t_rgb       rgb;
        logic       nmi_request;
        logic       vblank_flag;
    } t_result;

    function automatic t_rgb color_rgb(input logic [1:0] color);
        t_rgb c;
        case (color)
            2'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            2'd1:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            2'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/tile_background_video_unit.sv -----
// ----------------------------------------------------------------------------
// tile_background_video_unit
// Tile map background renderer with dot and line timing and a register port.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one transaction per command: a dot tick, a
// register write or a direct pattern load, selected by s_tuser. The master
// channel carries one result for each tick on a visible dot and for the tick
// that starts vertical blank; other transactions give no result.
// A tick's result passes the operation queue, tile read, pattern read and
// output registers. With m_tready held high it takes one transaction every cycle.
// After reset the tile map and both pattern banks are cleared one entry per
// bank per cycle; s_tready stays low until the clear is done.
// When the receiver stalls, the output register holds, the fetch pipeline
// freezes, and a four-entry operation queue keeps taking transactions until
// it fills, at which point s_tready drops.
// ----------------------------------------------------------------------------
module tile_background_video_unit #(
    parameter int DOTS_PER_LINE   = 340,
    parameter int LINES_PER_FRAME = 262,
    parameter int VBLANK_LINE     = 242
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_sel[2:0], load_addr[14:3], data_byte[22:15]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_x[7:0], pixel_y[15:8], color_index[17:16],
                                   // red[25:18], green[33:26], blue[41:34],
                                   // nmi_request[42], vblank_flag[43]
    output logic        m_tuser    // event_kind[0]
);

    logic               clearing;
    logic               push;
    logic               pop;
    tbv_pkg::t_op       front_op;
    tbv_pkg::t_op       queue_op;
    tbv_pkg::t_q_status q_status;
    tbv_pkg::t_result   result;

    tbv_front #(
        .DOTS_PER_LINE  (DOTS_PER_LINE),
        .LINES_PER_FRAME(LINES_PER_FRAME),
        .VBLANK_LINE    (VBLANK_LINE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_cmd      (s_tuser),
        .i_reg_sel  (s_tdata[2:0]),
        .i_load_addr(s_tdata[14:3]),
        .i_data_byte(s_tdata[22:15]),
        .i_clearing (clearing),
        .i_q_status (q_status),
        .o_push     (push),
        .o_op       (front_op)
    );

    tbv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_status(q_status)
    );

    tbv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(q_status),
        .i_op      (queue_op),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_result  (result)
    );

    assign m_tuser = result.event_kind;
    assign m_tdata = {4'h0, result.vblank_flag, result.nmi_request,
                      result.rgb.blue, result.rgb.green, result.rgb.red,
                      result.color_index, result.pixel_y, result.pixel_x};

endmodule

// ----- rtl/core/tbv_front.sv -----
// ----------------------------------------------------------------------------
// tbv_front
// Accepts input transactions, runs the dot and line counters and the register
// file, and turns each transaction into at most one operation for the back end.
// ----------------------------------------------------------------------------
module tbv_front #(
    parameter int DOTS_PER_LINE   = 340,
    parameter int LINES_PER_FRAME = 262,
    parameter int VBLANK_LINE     = 242
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [2:0]                    i_reg_sel,
    input  logic [tbv_pkg::PAT_AW-1:0]    i_load_addr,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_clearing,
    input  tbv_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output tbv_pkg::t_op                  o_op
);

    localparam int CW = tbv_pkg::CNT_W;
    localparam logic [CW-1:0] DOTS_END  = CW'(DOTS_PER_LINE);
    localparam logic [CW-1:0] LINES_END = CW'(LINES_PER_FRAME);
    localparam logic [CW-1:0] VB_LINE   = CW'(VBLANK_LINE);
    localparam logic [CW-1:0] PRE_LINE  = CW'(LINES_PER_FRAME - 1);

    logic [CW-1:0] r_dot, n_dot;
    logic [CW-1:0] r_line, n_line;
    logic [7:0]    r_ctrl, n_ctrl;
    logic          r_vblank, n_vblank;
    logic [15:0]   r_vram, n_vram;
    logic          r_pending, n_pending;

    logic          accept;
    logic          in_vis;
    logic          vb_start;
    logic          pre_clear;
    logic [CW-1:0] dot_inc;

    assign o_ready = !i_clearing && !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_dot     = r_dot;
        n_line    = r_line;
        n_ctrl    = r_ctrl;
        n_vblank  = r_vblank;
        n_vram    = r_vram;
        n_pending = r_pending;
        o_push    = 1'b0;
        o_op      = '0;

        in_vis    = (r_line >= tbv_pkg::VIS_FIRST) && (r_line <= tbv_pkg::VIS_LAST_Y) &&
                    (r_dot >= tbv_pkg::VIS_FIRST) && (r_dot <= tbv_pkg::VIS_LAST_X);
        vb_start  = (r_line == VB_LINE) && (r_dot == '0);
        pre_clear = (r_line == PRE_LINE) && (r_dot == '0);
        dot_inc   = r_dot + CW'(1);

        if (accept) begin
            case (tbv_pkg::t_cmd'(i_cmd))
                tbv_pkg::CMD_TICK: begin
                    if (vb_start) begin
                        n_vblank = 1'b1;
                    end
                    if (pre_clear) begin
                        n_vblank = 1'b0;
                    end
                    o_op.x     = 8'(r_dot - CW'(1));
                    o_op.y     = 8'(r_line - CW'(1));
                    o_op.vflag = n_vblank;
                    if (vb_start) begin
                        o_push    = 1'b1;
                        o_op.kind = tbv_pkg::OP_VBLANK;
                        o_op.nmi  = r_ctrl[7];
                    end else if (in_vis) begin
                        o_push    = 1'b1;
                        o_op.kind = tbv_pkg::OP_PIXEL;
                    end
                    if (dot_inc >= DOTS_END) begin
                        n_dot  = '0;
                        n_line = r_line + CW'(1);
                    end else begin
                        n_dot = dot_inc;
                    end
                    if (n_line >= LINES_END) begin
                        n_line = '0;
                        n_dot  = '0;
                    end
                end
                tbv_pkg::CMD_REG_WRITE: begin
                    case (i_reg_sel)
                        tbv_pkg::REG_CONTROL: begin
                            n_ctrl = i_data_byte;
                        end
                        tbv_pkg::REG_ADDRESS: begin
                            n_vram    = r_pending ? {r_vram[7:0], i_data_byte}
                                                  : {8'h00, i_data_byte};
                            n_pending = !r_pending;
                        end
                        tbv_pkg::REG_DATA: begin
                            o_op.data = i_data_byte;
                            if (r_vram < tbv_pkg::PATTERN_LIMIT) begin
                                o_push    = 1'b1;
                                o_op.kind = tbv_pkg::OP_PAT_WRITE;
                                o_op.addr = r_vram[tbv_pkg::PAT_AW-1:0];
                            end else if ((r_vram >= tbv_pkg::TILE_BASE) &&
                                         (r_vram < tbv_pkg::TILE_LIMIT)) begin
                                o_push    = 1'b1;
                                o_op.kind = tbv_pkg::OP_TILE_WRITE;
                                o_op.addr = tbv_pkg::PAT_AW'(r_vram[tbv_pkg::TILE_AW-1:0]);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                tbv_pkg::CMD_PAT_LOAD: begin
                    o_push    = 1'b1;
                    o_op.kind = tbv_pkg::OP_PAT_WRITE;
                    o_op.addr = i_load_addr;
                    o_op.data = i_data_byte;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot     <= '0;
            r_line    <= '0;
            r_ctrl    <= '0;
            r_vblank  <= 1'b0;
            r_vram    <= '0;
            r_pending <= 1'b0;
        end else begin
            r_dot     <= n_dot;
            r_line    <= n_line;
            r_ctrl    <= n_ctrl;
            r_vblank  <= n_vblank;
            r_vram    <= n_vram;
            r_pending <= n_pending;
        end
    end

endmodule

// ----- rtl/core/tbv_queue.sv -----
// ----------------------------------------------------------------------------
// tbv_queue
// Short first-in first-out queue of operations between front and back end.
// ----------------------------------------------------------------------------
module tbv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tbv_pkg::t_op       i_op,
    input  logic               i_pop,
    output tbv_pkg::t_op       o_op,
    output tbv_pkg::t_q_status o_status
);

    localparam int DEPTH = tbv_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tbv_pkg::t_op  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_op           = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/tbv_back.sv -----
// ----------------------------------------------------------------------------
// tbv_back
// Holds the tile map and the two pattern plane banks, clears them after reset,
// and runs the fetch pipeline that turns queued operations into results.
// ----------------------------------------------------------------------------
module tbv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbv_pkg::t_q_status  i_q_status,
    input  tbv_pkg::t_op        i_op,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_valid,
    input  logic                i_ready,
    output tbv_pkg::t_result    o_result
);

    localparam int BW = tbv_pkg::BANK_AW;
    localparam int TW = tbv_pkg::TILE_AW;
    localparam int BANK_DEPTH = 2 ** BW;
    localparam int TILE_DEPTH = 2 ** TW;

    logic [7:0] r_tile_mem [TILE_DEPTH];
    logic [7:0] r_lo_mem   [BANK_DEPTH];
    logic [7:0] r_hi_mem   [BANK_DEPTH];

    logic          r_clearing;
    logic [BW-1:0] r_clr_idx;

    logic          adv;
    logic          a_result;
    logic [TW-1:0] tile_rd_addr;
    logic [BW-1:0] pat_wr_addr;
    logic [BW-1:0] pat_rd_addr;

    logic [7:0]    r_tile_rd;
    logic          r_b_valid;
    tbv_pkg::t_op  r_b_op;

    logic [7:0]    r_c_lo;
    logic [7:0]    r_c_hi;
    logic          r_c_valid;
    tbv_pkg::t_op  r_c_op;

    logic [2:0]    bit_sel;
    logic [1:0]    color;
    tbv_pkg::t_result n_result;

    logic             r_out_valid;
    tbv_pkg::t_result r_result;

    assign adv        = !r_out_valid || i_ready;
    assign o_pop      = adv && !r_clearing && !i_q_status.empty;
    assign o_clearing = r_clearing;
    assign o_valid    = r_out_valid;
    assign o_result   = r_result;

    assign a_result     = (i_op.kind == tbv_pkg::OP_PIXEL) || (i_op.kind == tbv_pkg::OP_VBLANK);
    assign tile_rd_addr = {i_op.y[7:3], i_op.x[7:3]};
    assign pat_wr_addr  = {i_op.addr[tbv_pkg::PAT_AW-1:4], i_op.addr[2:0]};
    assign pat_rd_addr  = {r_tile_rd, r_b_op.y[2:0]};

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_tile_mem[r_clr_idx[TW-1:0]] <= '0;
        end else if (o_pop && (i_op.kind == tbv_pkg::OP_TILE_WRITE)) begin
            r_tile_mem[i_op.addr[TW-1:0]] <= i_op.data;
        end
        if (adv) begin
            r_tile_rd <= r_tile_mem[tile_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_lo_mem[r_clr_idx] <= '0;
        end else if (o_pop && (i_op.kind == tbv_pkg::OP_PAT_WRITE) && !i_op.addr[3]) begin
            r_lo_mem[pat_wr_addr] <= i_op.data;
        end
        if (adv) begin
            r_c_lo <= r_lo_mem[pat_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_hi_mem[r_clr_idx] <= '0;
        end else if (o_pop && (i_op.kind == tbv_pkg::OP_PAT_WRITE) && i_op.addr[3]) begin
            r_hi_mem[pat_wr_addr] <= i_op.data;
        end
        if (adv) begin
            r_c_hi <= r_hi_mem[pat_rd_addr];
        end
    end

    always_comb begin
        bit_sel  = ~r_c_op.x[2:0];
        color    = {r_c_hi[bit_sel], r_c_lo[bit_sel]};
        n_result = '0;
        n_result.vblank_flag = r_c_op.vflag;
        if (r_c_op.kind == tbv_pkg::OP_VBLANK) begin
            n_result.event_kind  = tbv_pkg::EV_VBLANK;
            n_result.nmi_request = r_c_op.nmi;
        end else begin
            n_result.event_kind  = tbv_pkg::EV_PIXEL;
            n_result.pixel_x     = r_c_op.x;
            n_result.pixel_y     = r_c_op.y;
            n_result.color_index = color;
            n_result.rgb         = tbv_pkg::color_rgb(color);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_op   <= i_op;
            r_c_op   <= r_b_op;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + BW'(1);
                if (r_clr_idx == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (adv) begin
                r_b_valid   <= o_pop && a_result;
                r_c_valid   <= r_b_valid;
                r_out_valid <= r_c_valid;
            end
        end
    end

endmodule

// ----- rtl/core/tbv_checker.sv -----
// ----------------------------------------------------------------------------
// tbv_checker
// Port-level checks for the tile background video unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    `TBV_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `TBV_ASSERT(a_vblank_zero, i_clk, i_rst_n, m_tvalid && m_tuser |-> m_tdata[41:0] == 42'd0)
    `TBV_ASSERT(a_vblank_flag, i_clk, i_rst_n, m_tvalid && m_tuser |-> m_tdata[43])
    `TBV_ASSERT(a_pixel_no_nmi, i_clk, i_rst_n, m_tvalid && !m_tuser |-> !m_tdata[42])
    `TBV_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !m_tvalid && !s_tready)

endmodule

bind tile_background_video_unit tbv_checker u_tbv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
